// ----- hw/rtl/pmst_pkg.sv -----
// Shared command and status types for the Prim spanning tree block.
`default_nettype none

package pmst_pkg;

   // Controller to datapath commands, at most one step a cycle
   typedef struct packed {
      logic load;        // store one matrix entry
      logic init;        // clear tree, start first pass from vertex 0
      logic scan_issue;  // issue one row read of the current pass
      logic pick;        // take the chosen vertex, start next pass
      logic out_begin;   // point the output walk at vertex 1
      logic out_mat;     // fetch the reported edge weight
      logic out_emit;    // present one edge and step
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic n_ok;        // vertex count is two or more
      logic v_last;      // vertex counter sits on n-1
      logic last_pass;   // the pass just drained was the final one
   } sts_type;

endpackage

`default_nettype wire

// ----- hw/rtl/pmst_dpath.sv -----
// Datapath: matrix, key and parent memories, tree flags and scan pipeline.
`default_nettype none

module pmst_dpath
   import pmst_pkg::*;
#(
   parameter int MAX_VERTICES = 32,
   parameter int WEIGHT_BITS  = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   input  wire logic [4:0]  req_row,
   input  wire logic [4:0]  req_col,
   input  wire logic [15:0] req_weight,
   input  wire logic        csr_wr_en,
   input  wire logic [5:0]  csr_wr_data,
   output logic [4:0]       rsp_parent_vertex,
   output logic [4:0]       rsp_child_vertex,
   output logic [15:0]      rsp_edge_weight,
   output logic             rsp_reachable,
   output logic             rsp_final_edge
);

   localparam int Limit = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
   localparam int VB    = $clog2(MAX_VERTICES);
   localparam int CW    = $clog2(Limit + 1);
   localparam int Depth = MAX_VERTICES * MAX_VERTICES;
   localparam int AW    = $clog2(Depth);
   localparam int WB    = WEIGHT_BITS;

   // memories
   logic [WB-1:0] mat_mem [Depth];
   logic [WB-1:0] key_mem [MAX_VERTICES];
   logic [VB-1:0] par_mem [MAX_VERTICES];
   logic [WB-1:0] mat_rd_ff;
   logic [WB-1:0] key_rd_ff;
   logic [VB-1:0] par_rd_ff;

   // control and scan registers
   logic [5:0]              nv_ff, nv_in;
   logic [VB-1:0]           u_ff, u_in;
   logic [CW-1:0]           v_ff, v_in;
   logic [CW-1:0]           round_ff, round_in;
   logic                    relax_en_ff, relax_en_in;
   logic                    best_found_ff, best_found_in;
   logic [WB-1:0]           best_key_ff, best_key_in;
   logic [VB-1:0]           best_v_ff, best_v_in;
   logic                    free_found_ff, free_found_in;
   logic [VB-1:0]           free_v_ff, free_v_in;
   logic                    s1_vld_ff, s1_vld_in;
   logic [VB-1:0]           s1_v_ff, s1_v_in;
   logic [MAX_VERTICES-1:0] in_tree_ff, in_tree_in;
   logic [MAX_VERTICES-1:0] reached_ff, reached_in;
   logic [VB-1:0]           p_ff, p_in;

   logic [CW-1:0] n_act;
   logic [VB-1:0] v_idx;
   logic [VB-1:0] pick_v;
   logic          s1_in_tree;
   logic          s1_reached;
   logic          relax;
   logic          new_rch;
   logic [WB-1:0] new_key;
   logic          take_best;
   logic          take_free;
   logic          wr_ok;
   logic [31:0]   wr_wide;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;

   assign v_idx = v_ff[VB-1:0];

   // active vertex count, saturated to what is built and addressable
   always_comb begin
      n_act = (nv_ff > 6'(Limit)) ? CW'(Limit) : CW'(nv_ff);
   end

   assign sts.n_ok      = (n_act >= CW'(2));
   assign sts.v_last    = (v_ff == n_act - CW'(1));
   assign sts.last_pass = (round_ff + CW'(2) == n_act);

   // scan stage two: relax one neighbor and fold it into the next pick
   assign s1_in_tree = in_tree_ff[s1_v_ff];
   assign s1_reached = reached_ff[s1_v_ff];
   assign relax      = s1_vld_ff & relax_en_ff & ~s1_in_tree & (mat_rd_ff != '0) &
                       (~s1_reached | (mat_rd_ff < key_rd_ff));
   assign new_key    = relax ? mat_rd_ff : key_rd_ff;
   assign new_rch    = s1_reached | relax;
   assign take_best  = s1_vld_ff & ~s1_in_tree & new_rch &
                       (~best_found_ff | (new_key < best_key_ff));
   assign take_free  = s1_vld_ff & ~s1_in_tree & ~free_found_ff;
   assign pick_v     = best_found_ff ? best_v_ff : free_v_ff;

   always_comb begin
      nv_in         = nv_ff;
      u_in          = u_ff;
      v_in          = v_ff;
      round_in      = round_ff;
      relax_en_in   = relax_en_ff;
      best_found_in = best_found_ff;
      best_key_in   = best_key_ff;
      best_v_in     = best_v_ff;
      free_found_in = free_found_ff;
      free_v_in     = free_v_ff;
      s1_vld_in     = 1'b0;
      s1_v_in       = s1_v_ff;
      in_tree_in    = in_tree_ff;
      reached_in    = reached_ff;
      p_in          = p_ff;

      if (csr_wr_en) begin
         nv_in = csr_wr_data;
      end
      if (cmd.init) begin
         u_in          = '0;
         v_in          = '0;
         round_in      = '0;
         relax_en_in   = 1'b1;
         best_found_in = 1'b0;
         free_found_in = 1'b0;
         in_tree_in    = MAX_VERTICES'(1);
         reached_in    = MAX_VERTICES'(1);
      end
      if (cmd.pick) begin
         u_in               = pick_v;
         v_in               = '0;
         round_in           = round_ff + CW'(1);
         relax_en_in        = reached_ff[pick_v];
         best_found_in      = 1'b0;
         free_found_in      = 1'b0;
         in_tree_in[pick_v] = 1'b1;
      end
      if (cmd.scan_issue) begin
         v_in      = v_ff + CW'(1);
         s1_vld_in = 1'b1;
         s1_v_in   = v_idx;
      end
      if (take_best) begin
         best_found_in = 1'b1;
         best_key_in   = new_key;
         best_v_in     = s1_v_ff;
      end
      if (take_free) begin
         free_found_in = 1'b1;
         free_v_in     = s1_v_ff;
      end
      if (relax) begin
         reached_in[s1_v_ff] = 1'b1;
      end
      if (cmd.out_begin) begin
         v_in = CW'(1);
      end
      if (cmd.out_mat) begin
         p_in = reached_ff[v_idx] ? par_rd_ff : '0;
      end
      if (cmd.out_emit) begin
         v_in = v_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff     <= 6'd32;
         s1_vld_ff <= 1'b0;
      end else begin
         nv_ff     <= nv_in;
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff          <= u_in;
      v_ff          <= v_in;
      round_ff      <= round_in;
      relax_en_ff   <= relax_en_in;
      best_found_ff <= best_found_in;
      best_key_ff   <= best_key_in;
      best_v_ff     <= best_v_in;
      free_found_ff <= free_found_in;
      free_v_ff     <= free_v_in;
      s1_v_ff       <= s1_v_in;
      in_tree_ff    <= in_tree_in;
      reached_ff    <= reached_in;
      p_ff          <= p_in;
   end

   // matrix write from load, read for scan or output lookup
   assign wr_ok   = (32'(req_row) < MAX_VERTICES) && (32'(req_col) < MAX_VERTICES);
   assign wr_wide = 32'(req_weight);
   assign wr_addr = AW'(32'(req_row) * MAX_VERTICES + 32'(req_col));
   assign rd_addr = cmd.out_mat ? AW'(32'(v_idx) * MAX_VERTICES + 32'(p_in))
                                : AW'(32'(u_ff) * MAX_VERTICES + 32'(v_idx));

   always_ff @(posedge clock) begin
      if (cmd.load && wr_ok) begin
         mat_mem[wr_addr] <= wr_wide[WB-1:0];
      end
      mat_rd_ff <= mat_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (relax) begin
         key_mem[s1_v_ff] <= mat_rd_ff;
      end
      key_rd_ff <= key_mem[v_idx];
   end

   always_ff @(posedge clock) begin
      if (relax) begin
         par_mem[s1_v_ff] <= u_ff;
      end
      par_rd_ff <= par_mem[v_idx];
   end

   assign rsp_parent_vertex = 5'(p_ff);
   assign rsp_child_vertex  = 5'(v_ff);
   assign rsp_edge_weight   = reached_ff[v_idx] ? 16'(mat_rd_ff) : 16'd0;
   assign rsp_reachable     = reached_ff[v_idx];
   assign rsp_final_edge    = sts.v_last;

`ifndef SYNTH
   a_pick_free: assert property (@(posedge clock) disable iff (reset)
      cmd.pick |-> !in_tree_ff[pick_v])
      else $error("picked vertex already in tree");
   a_s1_from_issue: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff |-> $past(cmd.scan_issue))
      else $error("scan stage two without an issued read");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/pmst_ctrl.sv -----
// Controller state machine: load, Prim passes and edge output sequencing.
`default_nettype none

module pmst_ctrl
   import pmst_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    req_last,
   input  wire sts_type sts,
   output cmd_type      cmd,
   output logic         busy,
   output logic         rsp_valid
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_INIT  = 8'b0000_0010,
      ST_SCAN  = 8'b0000_0100,
      ST_DRAIN = 8'b0000_1000,
      ST_PICK  = 8'b0001_0000,
      ST_OPAR  = 8'b0010_0000,
      ST_OMAT  = 8'b0100_0000,
      ST_EMIT  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (req_last && sts.n_ok) begin
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (sts.v_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_PICK;
         end
         ST_PICK: begin
            if (sts.last_pass) begin
               cmd.out_begin = 1'b1;
               state_in      = ST_OPAR;
            end else begin
               cmd.pick = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_OPAR: begin
            state_in = ST_OMAT;
         end
         ST_OMAT: begin
            cmd.out_mat = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.out_emit = 1'b1;
            state_in     = sts.v_last ? ST_IDLE : ST_OPAR;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);

`ifndef SYNTH
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start && req_last))
      else $error("busy rose without a last transaction");
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held two cycles");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/prim_mst_adjacency_matrix.sv -----
// Top level: Prim minimum spanning tree over a loaded adjacency matrix.
//
//  channel   ports            handshake                   direction
//  -------   --------------   -------------------------   ---------
//  request   start, req_*     start & !busy               in
//  result    rsp_*            rsp_valid, one cycle        out
//  config    csr_wr_*         csr_wr_en, single register  in
//
// A non-last entry is stored in the cycle it is taken; busy stays low and the
// next transaction may follow in the next cycle.
// A last entry with n >= 2 active vertices raises busy for an init state,
// then n-1 passes over one matrix row each (n reads through the single
// registered read port of the matrix memory, a drain state, a pick state),
// then for each reported edge a parent read, a weight read and the strobe.
// Reset is synchronous and active high; the matrix memory is not cleared.
// Results cannot be stalled: each edge is on rsp_* for exactly one cycle.
`default_nettype none

module prim_mst_adjacency_matrix
   import pmst_pkg::*;
#(
   parameter int MAX_VERTICES = 32,
   parameter int WEIGHT_BITS  = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        start,
   output logic             busy,
   input  wire logic [4:0]  req_row,
   input  wire logic [4:0]  req_col,
   input  wire logic [15:0] req_weight,
   input  wire logic        req_last,
   // result channel
   output logic             rsp_valid,
   output logic [4:0]       rsp_parent_vertex,
   output logic [4:0]       rsp_child_vertex,
   output logic [15:0]      rsp_edge_weight,
   output logic             rsp_reachable,
   output logic             rsp_final_edge,
   // vertex count register
   input  wire logic        csr_wr_en,
   input  wire logic [5:0]  csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   // sequencer: accepts transactions and steps the datapath
   pmst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_last  (req_last),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // storage and the per-pass relax/min scan
   pmst_dpath #(
      .MAX_VERTICES (MAX_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_row           (req_row),
      .req_col           (req_col),
      .req_weight        (req_weight),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_parent_vertex (rsp_parent_vertex),
      .rsp_child_vertex  (rsp_child_vertex),
      .rsp_edge_weight   (rsp_edge_weight),
      .rsp_reachable     (rsp_reachable),
      .rsp_final_edge    (rsp_final_edge)
   );

endmodule

`default_nettype wire
